// ===== design/ray_endpoint_pullback_unit_assert.svh =====
// Assertion macros for the checker of the ray end-point pull-back unit.
// Each macro expands to one labelled concurrent assertion that reports by $error.
`ifndef RAY_ENDPOINT_PULLBACK_UNIT_ASSERT_SVH
`define RAY_ENDPOINT_PULLBACK_UNIT_ASSERT_SVH

// Assertion that is switched off while reset is applied.
`define REPU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that also holds during reset.
`define REPU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rep_pkg.sv =====
// Package for the ray end-point pull-back unit: register indexes, widths and
// fixed constants. No dependencies.
`default_nettype none
package rep_pkg;
  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULLBACK_DIST = 2'd1;

  // Pull-back distance register.
  localparam int PD_W = 17;
  localparam logic [PD_W-1:0] PD_RESET = 17'd6554;

  // Fraction format: unsigned with 24 fractional bits.
  localparam int FRAC_SHIFT = 24;
  localparam logic [FRAC_SHIFT-1:0] FRAC_HALF = 24'h800000;

  // Stages outside the square-root and divider chains.
  localparam int FIXED_STAGES = 6;
endpackage
`default_nettype wire

// ===== design/rep_sqrt_cell.sv =====
// One cell of the square-root chain: resolves one root bit per cycle.
// Depends on nothing but its ports; the item's other fields ride alongside.
`default_nettype none
module rep_sqrt_cell #(
  parameter int RW  = 33,
  parameter int SBW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld_i,
  input  wire logic [2*RW-1:0]   rad_i,
  input  wire logic [RW+1:0]     rem_i,
  input  wire logic [RW-1:0]     root_i,
  input  wire logic [SBW-1:0]    sb_i,
  output logic                   vld_o,
  output logic [2*RW-1:0]        rad_o,
  output logic [RW+1:0]          rem_o,
  output logic [RW-1:0]          root_o,
  output logic [SBW-1:0]         sb_o
);
  localparam int SW = 2 * RW;

  logic [RW+3:0] cat;
  logic [RW+3:0] trial;
  logic          take;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    cat   = {rem_i, rad_i[SW-1 -: 2]};
    trial = cat - {2'b00, root_i, 2'b01};
    take  = !trial[RW+3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rad_o  <= {rad_i[SW-3:0], 2'b00};
    rem_o  <= take ? trial[RW+1:0] : cat[RW+1:0];
    root_o <= {root_i[RW-2:0], take};
    sb_o   <= sb_i;
  end
endmodule
`default_nettype wire

// ===== design/rep_div_cell.sv =====
// One cell of the restoring divider chain: one quotient bit per cycle.
// Depends on nothing but its ports; the item's other fields ride alongside.
`default_nettype none
module rep_div_cell #(
  parameter int RW  = 33,
  parameter int QW  = 24,
  parameter int SBW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           vld_i,
  input  wire logic [RW-1:0]  rem_i,
  input  wire logic [RW-1:0]  div_i,
  input  wire logic [QW-1:0]  q_i,
  input  wire logic [SBW-1:0] sb_i,
  output logic                vld_o,
  output logic [RW-1:0]       rem_o,
  output logic [RW-1:0]       div_o,
  output logic [QW-1:0]       q_o,
  output logic [SBW-1:0]      sb_o
);
  logic [RW:0] rem2;
  logic [RW:0] diff;
  logic        take;

  // Shift in a zero numerator bit and subtract the divisor when it fits.
  always_comb begin
    rem2 = {rem_i, 1'b0};
    diff = rem2 - {1'b0, div_i};
    take = (rem2 >= {1'b0, div_i});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_o <= take ? diff[RW-1:0] : rem2[RW-1:0];
    div_o <= div_i;
    q_o   <= {q_i[QW-2:0], take};
    sb_o  <= sb_i;
  end
endmodule
`default_nettype wire

// ===== design/ray_endpoint_pullback_unit.sv =====
// Ray end-point pull-back unit: a fully pipelined chain of cells.
// Pipeline from the accepted request to out_valid: six fixed stages, one cell per root bit
// and one per fraction bit.
// Throughput: one request per cycle; busy stays low and results cannot be held off.
// Reset (rst_n low, synchronous) empties the pipeline and restores both registers.
// Depends on rep_pkg, rep_sqrt_cell and rep_div_cell.
`default_nettype none
module ray_endpoint_pullback_unit
  import rep_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_wall_hit,
  input  wire logic signed [COORD_WIDTH-1:0] in_impact_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_impact_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_impact_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_target_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_target_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_target_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_start_z,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [PD_W-1:0]               cfg_data,
  output logic                               out_valid,
  output logic                               out_applied,
  output logic signed [COORD_WIDTH-1:0]      out_result_x,
  output logic signed [COORD_WIDTH-1:0]      out_result_y,
  output logic signed [COORD_WIDTH-1:0]      out_result_z
);
  localparam int CW  = COORD_WIDTH;
  localparam int MW  = CW + 1;
  localparam int RW  = CW + 1;
  localparam int SW  = 2 * RW;
  localparam int QW  = FRAC_SHIFT;
  localparam int PW  = MW + QW;
  localparam int SB1 = 1 + 3 * CW + 3 + 3 * MW + PD_W;
  localparam int SB2 = 1 + 3 * CW + 3 + 3 * MW + 1;

  localparam logic signed [CW+1:0] MAXV = (CW+2)'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [CW+1:0] MINV = -MAXV - (CW+2)'(1);

  // Configuration registers.
  logic            legacy_r;
  logic [PD_W-1:0] pd_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      legacy_r <= 1'b0;
      pd_r     <= PD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEGACY_MODE:   legacy_r <= cfg_data[0];
        CFG_PULLBACK_DIST: pd_r     <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Request fields gathered per axis.
  logic signed [CW-1:0] imp [3];
  logic signed [CW-1:0] tgt [3];
  logic signed [CW-1:0] st  [3];

  assign imp[0] = in_impact_x;
  assign imp[1] = in_impact_y;
  assign imp[2] = in_impact_z;
  assign tgt[0] = in_target_x;
  assign tgt[1] = in_target_y;
  assign tgt[2] = in_target_z;
  assign st[0]  = in_start_x;
  assign st[1]  = in_start_y;
  assign st[2]  = in_start_z;

  // Stage 0: guard, base point and ray delta.
  logic                 s0_vld_r;
  logic                 s0_app_r;
  logic [PD_W-1:0]      s0_pd_r;
  logic signed [CW-1:0] s0_base_r  [3];
  logic signed [MW-1:0] s0_delta_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_app_r <= legacy_r ? !in_wall_hit : in_wall_hit;
    s0_pd_r  <= pd_r;
    for (int a = 0; a < 3; a++) begin
      s0_base_r[a]  <= legacy_r ? tgt[a] : imp[a];
      s0_delta_r[a] <= MW'(tgt[a]) - MW'(st[a]);
    end
  end

  // Stage 1: magnitudes and squares.
  logic                 s1_vld_r;
  logic                 s1_app_r;
  logic [PD_W-1:0]      s1_pd_r;
  logic signed [CW-1:0] s1_base_r [3];
  logic [2:0]           s1_neg_r;
  logic [MW-1:0]        s1_mag_r  [3];
  logic [SW-1:0]        s1_sq_r   [3];
  logic [MW-1:0]        s0_mag    [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s0_mag[a] = s0_delta_r[a][MW-1] ? MW'(-s0_delta_r[a]) : MW'(s0_delta_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_app_r <= s0_app_r;
    s1_pd_r  <= s0_pd_r;
    for (int a = 0; a < 3; a++) begin
      s1_base_r[a] <= s0_base_r[a];
      s1_neg_r[a]  <= s0_delta_r[a][MW-1];
      s1_mag_r[a]  <= s0_mag[a];
      s1_sq_r[a]   <= SW'(s0_mag[a] * s0_mag[a]);
    end
  end

  // Stage 2: sum of squares.
  logic            s2_vld_r;
  logic [SW-1:0]   s2_sum_r;
  logic [SB1-1:0]  s2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_sum_r <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
    s2_sb_r  <= {s1_app_r, s1_base_r[0], s1_base_r[1], s1_base_r[2], s1_neg_r,
                 s1_mag_r[0], s1_mag_r[1], s1_mag_r[2], s1_pd_r};
  end

  // Square-root chain: one root bit per cell.
  logic            sq_vld  [RW+1];
  logic [SW-1:0]   sq_rad  [RW+1];
  logic [RW+1:0]   sq_rem  [RW+1];
  logic [RW-1:0]   sq_root [RW+1];
  logic [SB1-1:0]  sq_sb   [RW+1];

  assign sq_vld[0]  = s2_vld_r;
  assign sq_rad[0]  = s2_sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = s2_sb_r;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rep_sqrt_cell #(.RW(RW), .SBW(SB1)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (sq_vld[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .sb_i   (sq_sb[i]),
      .vld_o  (sq_vld[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .sb_o   (sq_sb[i+1])
    );
  end

  // Threshold stage: compare the distance with the pull-back length.
  logic            th_vld_r;
  logic [RW-1:0]   th_dist_r;
  logic [RW-1:0]   th_rem_r;
  logic [SB2-1:0]  th_sb_r;
  logic [PD_W-1:0] sq_pd;

  assign sq_pd = sq_sb[RW][PD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_vld_r <= 1'b0;
    end else begin
      th_vld_r <= sq_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    th_dist_r <= sq_root[RW];
    th_rem_r  <= RW'(sq_pd);
    th_sb_r   <= {sq_sb[RW][SB1-1:PD_W], (sq_root[RW] > RW'(sq_pd))};
  end

  // Divider chain: one fraction bit per cell.
  logic            dv_vld [QW+1];
  logic [RW-1:0]   dv_rem [QW+1];
  logic [RW-1:0]   dv_div [QW+1];
  logic [QW-1:0]   dv_q   [QW+1];
  logic [SB2-1:0]  dv_sb  [QW+1];

  assign dv_vld[0] = th_vld_r;
  assign dv_rem[0] = th_rem_r;
  assign dv_div[0] = th_dist_r;
  assign dv_q[0]   = '0;
  assign dv_sb[0]  = th_sb_r;

  for (genvar j = 0; j < QW; j++) begin : g_div
    rep_div_cell #(.RW(RW), .QW(QW), .SBW(SB2)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (dv_vld[j]),
      .rem_i (dv_rem[j]),
      .div_i (dv_div[j]),
      .q_i   (dv_q[j]),
      .sb_i  (dv_sb[j]),
      .vld_o (dv_vld[j+1]),
      .rem_o (dv_rem[j+1]),
      .div_o (dv_div[j+1]),
      .q_o   (dv_q[j+1]),
      .sb_o  (dv_sb[j+1])
    );
  end

  // Unpack the fields that rode through the divider.
  logic                 dv_gt;
  logic [MW-1:0]        dv_mag  [3];
  logic [2:0]           dv_neg;
  logic signed [CW-1:0] dv_base [3];
  logic                 dv_app;
  logic [QW-1:0]        frac;

  assign dv_gt      = dv_sb[QW][0];
  assign dv_mag[2]  = dv_sb[QW][1 +: MW];
  assign dv_mag[1]  = dv_sb[QW][1 + MW +: MW];
  assign dv_mag[0]  = dv_sb[QW][1 + 2 * MW +: MW];
  assign dv_neg     = dv_sb[QW][1 + 3 * MW +: 3];
  assign dv_base[2] = dv_sb[QW][4 + 3 * MW +: CW];
  assign dv_base[1] = dv_sb[QW][4 + 3 * MW + CW +: CW];
  assign dv_base[0] = dv_sb[QW][4 + 3 * MW + 2 * CW +: CW];
  assign dv_app     = dv_sb[QW][SB2-1];
  assign frac       = dv_gt ? dv_q[QW] : FRAC_HALF;

  // Product stage: pull amount before rounding.
  logic                 pr_vld_r;
  logic                 pr_app_r;
  logic [2:0]           pr_neg_r;
  logic signed [CW-1:0] pr_base_r [3];
  logic [PW-1:0]        pr_prod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
    end else begin
      pr_vld_r <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    pr_app_r <= dv_app;
    pr_neg_r <= dv_neg;
    for (int a = 0; a < 3; a++) begin
      pr_base_r[a] <= dv_base[a];
      pr_prod_r[a] <= dv_mag[a] * frac;
    end
  end

  // Output stage: round, apply the sign, subtract and saturate; a skipped request gives zero.
  logic [PW:0]          rnd  [3];
  logic [MW-1:0]        pull [3];
  logic signed [CW+1:0] diff [3];
  logic signed [CW-1:0] res  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rnd[a]  = {1'b0, pr_prod_r[a]} + ((PW+1)'(1) << (QW - 1));
      pull[a] = rnd[a][QW +: MW];
      diff[a] = pr_neg_r[a] ? ((CW+2)'(pr_base_r[a]) + (CW+2)'(pull[a]))
                            : ((CW+2)'(pr_base_r[a]) - (CW+2)'(pull[a]));
      if (!pr_app_r) begin
        res[a] = '0;
      end else if (diff[a] > MAXV) begin
        res[a] = MAXV[CW-1:0];
      end else if (diff[a] < MINV) begin
        res[a] = MINV[CW-1:0];
      end else begin
        res[a] = diff[a][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= pr_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_applied  <= pr_app_r;
    out_result_x <= res[0];
    out_result_y <= res[1];
    out_result_z <= res[2];
  end
endmodule
`default_nettype wire

// ===== design/rep_checker.sv =====
// Port-level checker for the ray end-point pull-back unit, bound to the top level.
// Depends on rep_pkg and ray_endpoint_pullback_unit_assert.svh.
`default_nettype none
`include "ray_endpoint_pullback_unit_assert.svh"
module rep_checker
  import rep_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   out_valid,
  input wire logic                   out_applied,
  input wire logic [COORD_WIDTH-1:0] out_result_x,
  input wire logic [COORD_WIDTH-1:0] out_result_y,
  input wire logic [COORD_WIDTH-1:0] out_result_z
);
  localparam int LAT = FIXED_STAGES + COORD_WIDTH + 1 + FRAC_SHIFT;

  logic req_taken;
  logic skipped;

  assign req_taken = start && !busy && rst_n;
  assign skipped   = out_valid && !out_applied;

  // Every accepted request comes out of the pipeline as a result.
  `REPU_ASSERT(a_latency, clk, rst_n, $past(req_taken, LAT) |-> out_valid, "result latency broken")

  // No result appears without an accepted request behind it.
  `REPU_ASSERT(a_no_extra, clk, rst_n, out_valid |-> $past(req_taken, LAT), "result without request")

  // A skipped request reports a zero point.
  `REPU_ASSERT(a_skip_zero, clk, rst_n, skipped |-> (out_result_x == '0 && out_result_y == '0 && out_result_z == '0), "skipped request has nonzero point")

  // The unit never holds requests off.
  `REPU_ASSERT_ALWAYS(a_no_busy, clk, !busy, "busy raised")
endmodule

bind ray_endpoint_pullback_unit rep_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rep_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_applied  (out_applied),
  .out_result_x (out_result_x),
  .out_result_y (out_result_y),
  .out_result_z (out_result_z)
);
`default_nettype wire
